### hw/rtl/wtfe_pkg.sv
// shared types and constants for the websocket text frame encoder
package wtfe_pkg;

    localparam int WTFE_FIFO_DEPTH = 4;

    localparam logic [7:0]  WTFE_HDR_B0        = 8'h81;
    localparam logic [31:0] WTFE_LEN_SHORT_MIN = 32'd126;
    localparam logic [31:0] WTFE_LEN_LONG_MIN  = 32'd65536;
    localparam logic [6:0]  WTFE_CODE_SHORT    = 7'h7E;
    localparam logic [6:0]  WTFE_CODE_LONG     = 7'h7F;

    // length encoding classes
    localparam logic [1:0] WTFE_LSEL_INLINE = 2'd0;
    localparam logic [1:0] WTFE_LSEL_SHORT  = 2'd1;
    localparam logic [1:0] WTFE_LSEL_LONG   = 2'd2;

    // extended length and mask key byte counts
    localparam logic [3:0] WTFE_EXT_SHORT = 4'd2;
    localparam logic [3:0] WTFE_EXT_LONG  = 4'd8;
    localparam logic [3:0] WTFE_KEY_BYTES = 4'd4;

    // fixed header positions
    localparam logic [3:0] WTFE_IDX_B0  = 4'd0;
    localparam logic [3:0] WTFE_IDX_LEN = 4'd1;
    localparam logic [3:0] WTFE_IDX_EXT = 4'd2;

    typedef struct packed {
        logic        is_hdr;
        logic        men;
        logic [1:0]  lsel;
        logic [3:0]  last_idx;
        logic [31:0] len;
        logic [31:0] key;
        logic [7:0]  data;
        logic        end_flag;
        logic        err;
    } t_cmd;

endpackage

### hw/rtl/wtfe_front.sv
// front end: takes input beats, tracks frame state, masks payload, queues commands
module wtfe_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_mode,
    input  logic [31:0]      i_frame_length,
    input  logic             i_mask_enable,
    input  logic [31:0]      i_mask_key,
    input  logic [7:0]       i_payload_byte,
    input  logic             i_full,
    output logic             o_push,
    output wtfe_pkg::t_cmd   o_cmd
);
    import wtfe_pkg::*;

    logic        r_frame_open, n_frame_open;
    logic [31:0] r_remaining, n_remaining;
    logic        r_masking, n_masking;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_key_pos, n_key_pos;

    logic        accept;
    logic [1:0]  lsel;
    logic [3:0]  ext_n;
    logic [3:0]  key_n;
    logic [7:0]  key_byte;
    logic [31:0] rem_dec;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    assign key_byte = r_masking ? r_key[{r_key_pos, 3'b000} +: 8] : 8'h00;
    assign rem_dec  = r_remaining - 32'd1;

    always_comb begin
        if (i_frame_length < WTFE_LEN_SHORT_MIN) begin
            lsel  = WTFE_LSEL_INLINE;
            ext_n = 4'd0;
        end else if (i_frame_length < WTFE_LEN_LONG_MIN) begin
            lsel  = WTFE_LSEL_SHORT;
            ext_n = WTFE_EXT_SHORT;
        end else begin
            lsel  = WTFE_LSEL_LONG;
            ext_n = WTFE_EXT_LONG;
        end
        key_n = i_mask_enable ? WTFE_KEY_BYTES : 4'd0;
    end

    always_comb begin
        n_frame_open = r_frame_open;
        n_remaining  = r_remaining;
        n_masking    = r_masking;
        n_key        = r_key;
        n_key_pos    = r_key_pos;

        o_cmd          = '0;
        o_cmd.len      = i_frame_length;
        o_cmd.key      = i_mask_key;
        o_cmd.men      = i_mask_enable;
        o_cmd.lsel     = lsel;

        if (!i_mode) begin
            o_cmd.is_hdr   = 1'b1;
            o_cmd.last_idx = WTFE_IDX_LEN + ext_n + key_n;
            o_cmd.end_flag = (i_frame_length == 32'd0);
            if (accept) begin
                n_masking    = i_mask_enable;
                n_key        = i_mask_enable ? i_mask_key : 32'd0;
                n_key_pos    = 2'd0;
                n_remaining  = i_frame_length;
                n_frame_open = (i_frame_length != 32'd0);
            end
        end else if (!r_frame_open) begin
            // stray payload byte passes through untouched
            o_cmd.data = i_payload_byte;
            o_cmd.err  = 1'b1;
        end else begin
            o_cmd.data     = i_payload_byte ^ key_byte;
            o_cmd.end_flag = (rem_dec == 32'd0);
            if (accept) begin
                n_remaining = rem_dec;
                if (r_masking) begin
                    n_key_pos = r_key_pos + 2'd1;
                end
                if (rem_dec == 32'd0) begin
                    n_frame_open = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_remaining  <= '0;
            r_masking    <= 1'b0;
            r_key        <= '0;
            r_key_pos    <= '0;
        end else begin
            r_frame_open <= n_frame_open;
            r_remaining  <= n_remaining;
            r_masking    <= n_masking;
            r_key        <= n_key;
            r_key_pos    <= n_key_pos;
        end
    end

endmodule

### hw/rtl/wtfe_fifo.sv
// short command queue between front and back end
module wtfe_fifo #(
    parameter int DEPTH = wtfe_pkg::WTFE_FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wtfe_pkg::t_cmd   i_cmd,
    input  logic             i_pop,
    output wtfe_pkg::t_cmd   o_head,
    output logic             o_empty,
    output logic             o_full
);
    import wtfe_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    logic do_push;
    logic do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full queue");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("queue count did not drop on pop");
`endif

endmodule

### hw/rtl/wtfe_back.sv
// back end: serialises queued commands into bytes behind an output register
module wtfe_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  wtfe_pkg::t_cmd   i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_frame_end,
    output logic             o_no_frame_error
);
    import wtfe_pkg::*;

    logic [3:0] r_idx, n_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last, r_end, r_err;

    logic       load;
    logic       is_last;
    logic [3:0] ext_n;
    logic [3:0] j;
    logic [3:0] k;
    logic [6:0] code;
    logic [7:0] hdr_byte;
    logic [7:0] cur_byte;

    assign load    = !i_empty && (!r_valid || !i_stall);
    assign is_last = (r_idx == i_head.last_idx);
    assign o_pop   = load && is_last;
    assign j       = r_idx - WTFE_IDX_EXT;

    always_comb begin
        unique case (i_head.lsel)
            WTFE_LSEL_SHORT: begin
                ext_n = WTFE_EXT_SHORT;
                code  = WTFE_CODE_SHORT;
            end
            WTFE_LSEL_LONG: begin
                ext_n = WTFE_EXT_LONG;
                code  = WTFE_CODE_LONG;
            end
            default: begin
                ext_n = 4'd0;
                code  = i_head.len[6:0];
            end
        endcase
        k = j - ext_n;
    end

    always_comb begin
        if (r_idx == WTFE_IDX_B0) begin
            hdr_byte = WTFE_HDR_B0;
        end else if (r_idx == WTFE_IDX_LEN) begin
            hdr_byte = {i_head.men, code};
        end else if (j < ext_n) begin
            if (i_head.lsel == WTFE_LSEL_SHORT) begin
                hdr_byte = i_head.len[{~j[0], 3'b000} +: 8];
            end else if (j < 4'd4) begin
                // top four bytes of the 64-bit length are always zero
                hdr_byte = 8'h00;
            end else begin
                hdr_byte = i_head.len[{~j[1:0], 3'b000} +: 8];
            end
        end else begin
            hdr_byte = i_head.key[{k[1:0], 3'b000} +: 8];
        end
        cur_byte = i_head.is_hdr ? hdr_byte : i_head.data;
    end

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = is_last ? 4'd0 : r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= cur_byte;
            r_last <= is_last;
            r_end  <= is_last && i_head.end_flag;
            r_err  <= i_head.err;
        end
    end

    assign o_valid          = r_valid;
    assign o_out_byte       = r_byte;
    assign o_run_last       = r_last;
    assign o_frame_end      = r_end;
    assign o_no_frame_error = r_err;

`ifndef SYNTH
    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_idx <= i_head.last_idx))
        else $error("byte index ran past the end of its command");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_empty |-> (r_idx == 4'd0))
        else $error("byte index not at zero with an empty queue");
`endif

endmodule

### hw/rtl/websocket_text_frame_encoder.sv
// websocket text frame encoder top level: front end, command queue, back end
// throughput: one output byte per cycle while i_stall is low and the queue holds a command
// a payload beat gives one output byte, a start beat 2 to 14
// input side takes one beat per cycle while the command queue has room
// queue depth FIFO_DEPTH commands; the back end serialiser sets the sustained byte rate
// synchronous active-low reset clears frame state, queue pointers and output valid
module websocket_text_frame_encoder #(
    parameter int FIFO_DEPTH = wtfe_pkg::WTFE_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [31:0] i_frame_length,
    input  logic        i_mask_enable,
    input  logic [31:0] i_mask_key,
    input  logic [7:0]  i_payload_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_frame_end,
    output logic        o_no_frame_error
);
    import wtfe_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    wtfe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_frame_length (i_frame_length),
        .i_mask_enable  (i_mask_enable),
        .i_mask_key     (i_mask_key),
        .i_payload_byte (i_payload_byte),
        .i_full         (q_full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    wtfe_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    wtfe_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (q_empty),
        .i_head           (head_cmd),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_run_last       (o_run_last),
        .o_frame_end      (o_frame_end),
        .o_no_frame_error (o_no_frame_error)
    );

endmodule
